@@ rtl/core/svbs_pkg.sv @@
// Shared types and constants of the sparse voxel brick store.
// Depends on nothing; every module of the store imports it.
package svbs_pkg;

   localparam int EDGE_BITS  = 3;
   localparam int FINE_BITS  = 9;
   localparam int WORD_BITS  = 64;
   localparam int WSEL_BITS  = 3;
   localparam int WCNT_BITS  = 4;
   localparam int COORD_W    = 11;
   localparam int COLOR_W    = 32;
   localparam int GRID_W     = 7;
   localparam int TSEL_W     = 8;
   localparam int CELL_OUT_W = 9;
   localparam int T_W        = 14;
   localparam int CELL_W     = 21;
   localparam int CMP_W      = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CSR_GRID_X = 2'd0;
   localparam logic [1:0] CSR_GRID_Y = 2'd1;
   localparam logic [1:0] CSR_GRID_Z = 2'd2;

   localparam logic [GRID_W-1:0] GRID_RESET = 7'd8;

   typedef enum logic [1:0] {
      CMD_INSERT_COLOR,
      CMD_INSERT_SHARED,
      CMD_DELETE,
      CMD_LOOKUP
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_OUT_OF_BOUNDS,
      ST_NO_CHANGE,
      ST_BAD_TEXTURE,
      ST_FULL
   } status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_CELL,
      BK_ZERO,
      BK_WORD,
      BK_SCAN,
      BK_COLOR,
      BK_DONE
   } bk_state_type;

   typedef struct packed {
      cmd_type                cmd;
      logic                   oob;
      logic [CELL_W-1:0]      cell_no;
      logic [FINE_BITS-1:0]   fine;
      logic [COLOR_W-1:0]     color;
      logic                   replace;
      logic [TSEL_W-1:0]      tsel;
   } item_type;

   typedef struct packed {
      status_type             status;
      logic [CELL_OUT_W-1:0]  cell_index;
      logic                   new_brick;
      logic                   brick_empty;
      logic                   voxel_present;
      logic [COLOR_W-1:0]     color;
   } rsp_type;

endpackage

@@ rtl/core/svbs_front.sv @@
// Front end: grid size registers, bounds check and cell flattening.
// Depends on svbs_pkg; feeds classified transactions into svbs_queue.
module svbs_front #(
   parameter int GRID_CELLS = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [1:0]                 command,
   input  logic signed [10:0]         pos_x,
   input  logic signed [10:0]         pos_y,
   input  logic signed [10:0]         pos_z,
   input  logic [31:0]                color_in,
   input  logic                       replace,
   input  logic [7:0]                 texture_select,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [6:0]                 csr_data,
   input  logic                       hold,
   input  logic                       q_full,
   output logic                       q_push,
   output svbs_pkg::item_type         q_item
);
   import svbs_pkg::*;

   logic [GRID_W-1:0]    grid_x_ff, grid_y_ff, grid_z_ff;
   logic                 a_valid_ff, a_valid_in;
   cmd_type              a_cmd_ff;
   logic                 a_oob_ff;
   logic [GRID_W-1:0]    a_cx_ff;
   logic [T_W-1:0]       a_t_ff;
   logic [FINE_BITS-1:0] a_fine_ff;
   logic [COLOR_W-1:0]   a_color_ff;
   logic                 a_replace_ff;
   logic [TSEL_W-1:0]    a_tsel_ff;

   logic                 accept;
   logic                 oob;
   logic [T_W-1:0]       t_val;
   logic [CELL_W-1:0]    cell_flat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff <= GRID_RESET;
         grid_y_ff <= GRID_RESET;
         grid_z_ff <= GRID_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GRID_X: grid_x_ff <= csr_data;
            CSR_GRID_Y: grid_y_ff <= csr_data;
            CSR_GRID_Z: grid_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign full   = hold | (a_valid_ff & q_full);
   assign accept = push & ~full;
   assign q_push = a_valid_ff & ~q_full;

   // negative coordinates, or brick coordinate past the grid
   assign oob = pos_x[10] | pos_y[10] | pos_z[10] |
                (pos_x[9:3] >= grid_x_ff) |
                (pos_y[9:3] >= grid_y_ff) |
                (pos_z[9:3] >= grid_z_ff);
   assign t_val = T_W'(grid_y_ff * pos_z[9:3]) + T_W'(pos_y[9:3]);

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (q_push) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_cmd_ff     <= cmd_type'(command);
         a_oob_ff     <= oob;
         a_cx_ff      <= pos_x[9:3];
         a_t_ff       <= t_val;
         a_fine_ff    <= {pos_z[2:0], pos_y[2:0], pos_x[2:0]};
         a_color_ff   <= color_in;
         a_replace_ff <= replace;
         a_tsel_ff    <= texture_select;
      end
   end

   assign cell_flat = CELL_W'(grid_x_ff * a_t_ff) + CELL_W'(a_cx_ff);

   always_comb begin
      q_item.cmd     = a_cmd_ff;
      q_item.oob     = a_oob_ff | (cell_flat >= CELL_W'(GRID_CELLS));
      q_item.cell_no = cell_flat;
      q_item.fine    = a_fine_ff;
      q_item.color   = a_color_ff;
      q_item.replace = a_replace_ff;
      q_item.tsel    = a_tsel_ff;
   end

endmodule

@@ rtl/core/svbs_queue.sv @@
// Two-entry queue of classified transactions between front and back end.
// Depends on svbs_pkg for the item type.
module svbs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  svbs_pkg::item_type  item_in,
   output logic                full,
   input  logic                pop,
   output svbs_pkg::item_type  item_out,
   output logic                empty
);
   import svbs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign item_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

@@ rtl/core/svbs_back.sv @@
// Back end: cell table, occupancy, texture pointer and color memories and
// the sequencer that carries out each transaction. Depends on svbs_pkg.
module svbs_back #(
   parameter int GRID_CELLS    = 512,
   parameter int TEXTURE_SLOTS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  svbs_pkg::item_type  q_item,
   output logic                q_pop,
   output logic                clearing,
   output logic                rsp_valid,
   output svbs_pkg::rsp_type   rsp,
   input  logic                rsp_pop
);
   import svbs_pkg::*;

   localparam int BW     = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
   localparam int BCW    = $clog2(GRID_CELLS + 1);
   localparam int TW     = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
   localparam int TCW    = $clog2(TEXTURE_SLOTS + 1);
   localparam int OCC_AW = BW + WSEL_BITS;
   localparam int COL_AW = TW + FINE_BITS;

   // memories
   logic [BW:0]          cell_mem [GRID_CELLS];
   logic [WORD_BITS-1:0] occ_mem  [GRID_CELLS * 8];
   logic [TW-1:0]        tex_mem  [GRID_CELLS];
   logic [COLOR_W-1:0]   col_mem  [TEXTURE_SLOTS * 512];

   logic [BW:0]          cell_rd_ff;
   logic [WORD_BITS-1:0] occ_rd_ff;
   logic [TW-1:0]        tex_rd_ff;
   logic [COLOR_W-1:0]   col_rd_ff;

   logic                 cell_we, occ_we, tex_we, col_we;
   logic [BW-1:0]        cell_waddr, cell_raddr, tex_waddr, tex_raddr;
   logic [BW:0]          cell_wdata;
   logic [OCC_AW-1:0]    occ_waddr, occ_raddr;
   logic [WORD_BITS-1:0] occ_wdata;
   logic [TW-1:0]        tex_wdata;
   logic [COL_AW-1:0]    col_waddr, col_raddr;
   logic [COLOR_W-1:0]   col_wdata;

   // sequencer state
   bk_state_type         state_ff, state_in;
   item_type             item_ff, item_in;
   logic [BW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [WCNT_BITS-1:0] wcnt_ff, wcnt_in;
   logic [BW-1:0]        brick_ff, brick_in;
   logic                 nonzero_ff, nonzero_in;
   logic [BCW-1:0]       brick_count_ff, brick_count_in;
   logic [TCW-1:0]       tex_count_ff, tex_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [WSEL_BITS-1:0] wsel;
   logic [5:0]           bsel;
   logic [WORD_BITS-1:0] mask;
   logic                 has;
   logic [BW-1:0]        cbrick;
   logic                 brick_full, tex_full, tsel_bad, vbit, last_clear;
   logic [CMP_W-1:0]     tsel_ext;
   logic [TW-1:0]        new_tex;

   assign wsel       = item_ff.fine[FINE_BITS-1:6];
   assign bsel       = item_ff.fine[5:0];
   assign mask       = WORD_BITS'(1) << bsel;
   assign has        = cell_rd_ff[BW];
   assign cbrick     = cell_rd_ff[BW-1:0];
   assign brick_full = brick_count_ff >= BCW'(GRID_CELLS);
   assign tex_full   = tex_count_ff >= TCW'(TEXTURE_SLOTS);
   assign tsel_ext   = CMP_W'(item_ff.tsel);
   assign tsel_bad   = tsel_ext >= CMP_W'(tex_count_ff);
   assign vbit       = occ_rd_ff[bsel];
   assign last_clear = clr_cnt_ff == BW'(GRID_CELLS - 1);
   assign new_tex    = (item_ff.cmd == CMD_INSERT_COLOR) ? tex_count_ff[TW-1:0]
                                                         : tsel_ext[TW-1:0];

   assign q_pop     = (state_ff == BK_IDLE) & ~q_empty & ~rsp_valid_ff;
   assign clearing  = state_ff == BK_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (last_clear) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (q_pop) state_in = q_item.oob ? BK_DONE : BK_CELL;
         end
         BK_CELL: begin
            case (item_ff.cmd)
               CMD_INSERT_COLOR: begin
                  if (has) state_in = BK_WORD;
                  else if (brick_full || tex_full) state_in = BK_DONE;
                  else state_in = BK_ZERO;
               end
               CMD_INSERT_SHARED: begin
                  if (has) state_in = BK_WORD;
                  else if (tsel_bad || brick_full) state_in = BK_DONE;
                  else state_in = BK_ZERO;
               end
               default: state_in = has ? BK_WORD : BK_DONE;
            endcase
         end
         BK_ZERO: begin
            if (wcnt_ff == WCNT_BITS'(7)) state_in = BK_DONE;
         end
         BK_WORD: begin
            case (item_ff.cmd)
               CMD_DELETE: state_in = BK_SCAN;
               CMD_LOOKUP: state_in = vbit ? BK_COLOR : BK_DONE;
               default:    state_in = BK_DONE;
            endcase
         end
         BK_SCAN: begin
            if (wcnt_ff == WCNT_BITS'(8)) state_in = BK_DONE;
         end
         BK_COLOR: state_in = BK_DONE;
         BK_DONE:  state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      item_in        = item_ff;
      clr_cnt_in     = clr_cnt_ff;
      wcnt_in        = wcnt_ff;
      brick_in       = brick_ff;
      nonzero_in     = nonzero_ff;
      brick_count_in = brick_count_ff;
      tex_count_in   = tex_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      cell_we        = 1'b0;
      cell_waddr     = item_ff.cell_no[BW-1:0];
      cell_wdata     = {1'b1, brick_count_ff[BW-1:0]};
      cell_raddr     = q_item.cell_no[BW-1:0];
      occ_we         = 1'b0;
      occ_waddr      = {brick_ff, wsel};
      occ_wdata      = occ_rd_ff | mask;
      occ_raddr      = {cbrick, wsel};
      tex_we         = 1'b0;
      tex_waddr      = brick_count_ff[BW-1:0];
      tex_wdata      = new_tex;
      tex_raddr      = cbrick;
      col_we         = 1'b0;
      col_waddr      = {tex_rd_ff, item_ff.fine};
      col_wdata      = item_ff.color;
      col_raddr      = {tex_rd_ff, item_ff.fine};

      if (rsp_pop && rsp_valid_ff) rsp_valid_in = 1'b0;

      case (state_ff)
         BK_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = clr_cnt_ff;
            cell_wdata = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         BK_IDLE: begin
            if (q_pop) begin
               item_in              = q_item;
               rsp_in.status        = q_item.oob ? ST_OUT_OF_BOUNDS : ST_OK;
               rsp_in.cell_index    = q_item.oob ? '0 : q_item.cell_no[CELL_OUT_W-1:0];
               rsp_in.new_brick     = 1'b0;
               rsp_in.brick_empty   = 1'b0;
               rsp_in.voxel_present = 1'b0;
               rsp_in.color         = '0;
            end
         end
         BK_CELL: begin
            brick_in = cbrick;
            wcnt_in  = '0;
            if (!has) begin
               case (item_ff.cmd)
                  CMD_INSERT_COLOR: begin
                     if (brick_full || tex_full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        // allocate brick and texture, write the color now
                        brick_in         = brick_count_ff[BW-1:0];
                        cell_we          = 1'b1;
                        tex_we           = 1'b1;
                        col_we           = 1'b1;
                        col_waddr        = {tex_count_ff[TW-1:0], item_ff.fine};
                        brick_count_in   = brick_count_ff + 1'b1;
                        tex_count_in     = tex_count_ff + 1'b1;
                        rsp_in.new_brick = 1'b1;
                     end
                  end
                  CMD_INSERT_SHARED: begin
                     if (tsel_bad) begin
                        rsp_in.status = ST_BAD_TEXTURE;
                     end else if (brick_full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        brick_in         = brick_count_ff[BW-1:0];
                        cell_we          = 1'b1;
                        tex_we           = 1'b1;
                        brick_count_in   = brick_count_ff + 1'b1;
                        rsp_in.new_brick = 1'b1;
                     end
                  end
                  CMD_DELETE: rsp_in.status = ST_NO_CHANGE;
                  default: ;
               endcase
            end
         end
         BK_ZERO: begin
            // sweep the new brick's mask, setting only the target voxel
            occ_we    = 1'b1;
            occ_waddr = {brick_ff, wcnt_ff[WSEL_BITS-1:0]};
            occ_wdata = (wcnt_ff[WSEL_BITS-1:0] == wsel) ? mask : '0;
            wcnt_in   = wcnt_ff + 1'b1;
         end
         BK_WORD: begin
            nonzero_in = 1'b0;
            case (item_ff.cmd)
               CMD_INSERT_COLOR: begin
                  if (item_ff.replace || !vbit) begin
                     occ_we = 1'b1;
                     col_we = 1'b1;
                  end else begin
                     rsp_in.status = ST_NO_CHANGE;
                  end
               end
               CMD_INSERT_SHARED: occ_we = 1'b1;
               CMD_DELETE: begin
                  occ_we    = 1'b1;
                  occ_wdata = occ_rd_ff & ~mask;
               end
               default: rsp_in.voxel_present = vbit;
            endcase
         end
         BK_SCAN: begin
            occ_raddr = {brick_ff, wcnt_ff[WSEL_BITS-1:0]};
            wcnt_in   = wcnt_ff + 1'b1;
            if (wcnt_ff != '0) nonzero_in = nonzero_ff | (occ_rd_ff != '0);
            rsp_in.brick_empty = ~(nonzero_ff | (occ_rd_ff != '0));
         end
         BK_COLOR: rsp_in.color = col_rd_ff;
         BK_DONE:  rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_CLEAR;
         clr_cnt_ff     <= '0;
         brick_count_ff <= '0;
         tex_count_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         brick_count_ff <= brick_count_in;
         tex_count_ff   <= tex_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      wcnt_ff    <= wcnt_in;
      brick_ff   <= brick_in;
      nonzero_ff <= nonzero_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
      occ_rd_ff <= occ_mem[occ_raddr];
   end

   always_ff @(posedge clock) begin
      if (tex_we) tex_mem[tex_waddr] <= tex_wdata;
      tex_rd_ff <= tex_mem[tex_raddr];
   end

   always_ff @(posedge clock) begin
      if (col_we) col_mem[col_waddr] <= col_wdata;
      col_rd_ff <= col_mem[col_raddr];
   end

   a_brick_bound: assert property (@(posedge clock) disable iff (reset)
      brick_count_ff <= BCW'(GRID_CELLS))
      else $error("brick count past the store size");

   a_tex_le_brick: assert property (@(posedge clock) disable iff (reset)
      BCW'(tex_count_ff) <= brick_count_ff)
      else $error("more textures than bricks");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == BK_DONE))
      else $error("result raised outside the done step");

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> !rsp_valid_ff && !q_pop)
      else $error("transaction handled during the clearing pass");

endmodule

@@ rtl/core/sparse_voxel_brick_store_core.sv @@
// Sparse voxel brick store. A request out of bounds goes straight to its
// result; otherwise the cell table is read, then a new brick has its
// eight-word mask swept, an existing brick's mask word is read (and written
// for insert), a lookup hit reads the color, and a delete rewrites the mask
// word and scans all eight words. The back end takes one transaction at a time.
// After reset the cell table is swept with req_full high.
module sparse_voxel_brick_store_core #(
   parameter int GRID_CELLS    = 512,
   parameter int TEXTURE_SLOTS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_command,
   input  logic signed [10:0] req_pos_x,
   input  logic signed [10:0] req_pos_y,
   input  logic signed [10:0] req_pos_z,
   input  logic [31:0]        req_color_in,
   input  logic               req_replace,
   input  logic [7:0]         req_texture_select,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [2:0]         rsp_status,
   output logic [8:0]         rsp_cell_index,
   output logic               rsp_new_brick,
   output logic               rsp_brick_empty,
   output logic               rsp_voxel_present,
   output logic [31:0]        rsp_color_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [6:0]         csr_data
);
   import svbs_pkg::*;

   item_type  fq_item, qb_item;
   logic      fq_push, fq_full, qb_pop, qb_empty, clearing, rsp_valid;
   rsp_type   rsp;

   svbs_front #(.GRID_CELLS(GRID_CELLS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (req_push),
      .full           (req_full),
      .command        (req_command),
      .pos_x          (req_pos_x),
      .pos_y          (req_pos_y),
      .pos_z          (req_pos_z),
      .color_in       (req_color_in),
      .replace        (req_replace),
      .texture_select (req_texture_select),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .hold           (clearing),
      .q_full         (fq_full),
      .q_push         (fq_push),
      .q_item         (fq_item)
   );

   svbs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fq_push),
      .item_in  (fq_item),
      .full     (fq_full),
      .pop      (qb_pop),
      .item_out (qb_item),
      .empty    (qb_empty)
   );

   svbs_back #(
      .GRID_CELLS    (GRID_CELLS),
      .TEXTURE_SLOTS (TEXTURE_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (qb_empty),
      .q_item    (qb_item),
      .q_pop     (qb_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_empty         = ~rsp_valid;
   assign rsp_status        = rsp.status;
   assign rsp_cell_index    = rsp.cell_index;
   assign rsp_new_brick     = rsp.new_brick;
   assign rsp_brick_empty   = rsp.brick_empty;
   assign rsp_voxel_present = rsp.voxel_present;
   assign rsp_color_out     = rsp.color;

endmodule
